// ----- rtl/core/ght_pkg.sv -----
// Shared types, constants and helpers for the generational handle table.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps
`default_nettype none
package ght_pkg;

  localparam int ENTITY_SLOTS_DEF    = 256;
  localparam int COMPONENT_SLOTS_DEF = 16;
  localparam int SYSTEM_SLOTS_DEF    = 4;
  localparam int ID_BITS  = 24;
  localparam int GEN_BITS = 8;
  localparam int NUM_CFG  = 6;

  typedef enum logic [2:0] {
    REQ_CREATE  = 3'd0,
    REQ_DESTROY = 3'd1,
    REQ_ATTACH  = 3'd2,
    REQ_DETACH  = 3'd3,
    REQ_QUERY   = 3'd4,
    REQ_CLEAR   = 3'd5,
    REQ_RSVD6   = 3'd6,
    REQ_RSVD7   = 3'd7
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_ALREADY = 3'd2,
    ST_FULL    = 3'd3,
    ST_BADCOMP = 3'd4
  } status_t;

  localparam logic [2:0] CFG_NUM_COMP = 3'd0;
  localparam logic [2:0] CFG_NUM_SYS  = 3'd1;
  localparam logic [2:0] CFG_SIG0     = 3'd2;
  localparam logic [2:0] CFG_SIG1     = 3'd3;
  localparam logic [2:0] CFG_SIG2     = 3'd4;
  localparam logic [2:0] CFG_SIG3     = 3'd5;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] handle;
    logic [4:0]  comp_kind;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_handle;
    logic [7:0]  dense_index;
    logic        has_bit;
    logic [3:0]  system_mask;
    logic [8:0]  live_count;
  } rsp_t;

  typedef struct packed {
    logic [4:0]  num_components;
    logic [2:0]  num_systems;
    logic [63:0] sigs;
  } cfg_t;

  // System match over a 32-bit (zero-extended) signature.
  function automatic logic [3:0] match_mask(input cfg_t c, input logic [31:0] sig,
                                            input logic [2:0] nslots);
    logic [3:0]  m;
    logic [2:0]  n;
    logic [15:0] s;
    m = '0;
    n = (c.num_systems < nslots) ? c.num_systems : nslots;
    for (int i = 0; i < 4; i++) begin
      s = c.sigs[i*16 +: 16];
      if ((3'(i) < n) && ((sig[15:0] & s) == s)) m[i] = 1'b1;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ght_cfg_regs.sv -----
// Configuration register file for the handle table.
// Depends on ght_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ght_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  output ght_pkg::cfg_t      cfg
);
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_components <= 5'd16;
      cfg.num_systems    <= 3'd0;
      cfg.sigs           <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ght_pkg::CFG_NUM_COMP: cfg.num_components <= cfg_data[4:0];
        ght_pkg::CFG_NUM_SYS:  cfg.num_systems    <= cfg_data[2:0];
        ght_pkg::CFG_SIG0:     cfg.sigs[15:0]     <= cfg_data;
        ght_pkg::CFG_SIG1:     cfg.sigs[31:16]    <= cfg_data;
        ght_pkg::CFG_SIG2:     cfg.sigs[47:32]    <= cfg_data;
        ght_pkg::CFG_SIG3:     cfg.sigs[63:48]    <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/generational_handle_table.sv -----
// Top level of the generational handle table: sequencer plus table memories.
// Depends on ght_pkg and ght_cfg_regs.
`timescale 1ns / 1ps
`default_nettype none
// One request at a time. After reset a clearing pass writes every slot of
// the map, handle and signature tables, during which no request is taken.
// Each step is one read of a table memory or a write-back. Failures end
// early: a full table or an unknown request type at acceptance, a bad
// component in the lookup state, an id with no live slot once the map is
// read, a stale generation once the handle is read. Clear retires the live
// entities one at a time from the last dense slot. The result is held in an
// output register until taken; the block then returns to idle before the
// next request is taken.
module generational_handle_table #(
  parameter int ENTITY_SLOTS    = ght_pkg::ENTITY_SLOTS_DEF,
  parameter int COMPONENT_SLOTS = ght_pkg::COMPONENT_SLOTS_DEF,
  parameter int SYSTEM_SLOTS    = ght_pkg::SYSTEM_SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  output      logic          cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  input  wire logic          in_valid,
  output      logic          in_stall,
  input  wire ght_pkg::req_t in_data,
  output      logic          out_valid,
  input  wire logic          out_stall,
  output      ght_pkg::rsp_t out_data
);
  localparam int AW = $clog2(ENTITY_SLOTS);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] SLOTS_C = CW'(ENTITY_SLOTS);
  localparam logic [2:0] SYS_C = 3'(SYSTEM_SLOTS);

  ght_pkg::cfg_t cfg;
  ght_cfg_regs u_cfg (.clk, .rst, .cfg_valid(cfg_valid & cfg_ready),
                      .cfg_index, .cfg_data, .cfg);
  assign cfg_ready = 1'b1;

  // Tables: map (invalid marker = top bit set), handle, signature, free stack.
  logic [CW-1:0] map_mem [ENTITY_SLOTS];
  logic [31:0]   hnd_mem [ENTITY_SLOTS];
  logic [15:0]   sig_mem [ENTITY_SLOTS];
  logic [AW-1:0] fre_mem [ENTITY_SLOTS];

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_LOOK, S_MAPW, S_HND, S_HNDW, S_SIG, S_SIGW,
    S_CR_FREE, S_CR_FREEW, S_CR_HND, S_CR_HNDW,
    S_DS_LAST, S_DS_LASTW, S_DS_MOVE, S_DS_FIN, S_DS_CLR, S_OUT
  } state_t;
  state_t state;

  ght_pkg::req_t req;
  logic [CW-1:0] live, freec, dpos, last;
  logic [AW-1:0] init_ptr;
  logic [31:0]   hnd_rd, ent_h, mov_h;
  logic [15:0]   sig_rd, mov_sig;
  logic [CW-1:0] map_rd;
  logic [AW-1:0] fre_rd;
  logic          clearing;

  // Single read port per memory; read data registered, address driven by the sequencer.
  logic [AW-1:0] map_ra, hnd_ra, sig_ra, fre_ra;
  logic          map_we, hnd_we, sig_we, fre_we;
  logic [AW-1:0] map_wa, hnd_wa, sig_wa, fre_wa;
  logic [CW-1:0] map_wd;
  logic [31:0]   hnd_wd;
  logic [15:0]   sig_wd;
  logic [AW-1:0] fre_wd;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (hnd_we) hnd_mem[hnd_wa] <= hnd_wd;
    if (sig_we) sig_mem[sig_wa] <= sig_wd;
    if (fre_we) fre_mem[fre_wa] <= fre_wd;
    map_rd <= map_mem[map_ra];
    hnd_rd <= hnd_mem[hnd_ra];
    sig_rd <= sig_mem[sig_ra];
    fre_rd <= fre_mem[fre_ra];
  end

  wire [AW-1:0] req_id    = req.handle[AW-1:0];
  wire          id_in     = (req.handle[23:0] < 24'(ENTITY_SLOTS));
  wire          comp_bad  = ({1'b0, req.comp_kind} >= {1'b0, cfg.num_components}) ||
                            (6'(req.comp_kind) >= 6'(COMPONENT_SLOTS));
  wire [15:0]   cbit      = 16'(32'd1 << req.comp_kind);
  wire [3:0]    mask_zero = ght_pkg::match_mask(cfg, 32'd0, SYS_C);
  // Create on a full table fails at once
  wire          create_full = (in_data.req_type == ght_pkg::REQ_CREATE) &&
                              (live >= SLOTS_C);

  logic [2:0]   st;
  logic [31:0]  oh;
  logic [7:0]   di;
  logic         hb;
  logic [3:0]   sm;

  wire req_is_rmw = (req.req_type == ght_pkg::REQ_ATTACH) ||
                    (req.req_type == ght_pkg::REQ_DETACH) ||
                    (req.req_type == ght_pkg::REQ_QUERY);

  always_comb begin
    map_we = 1'b0; hnd_we = 1'b0; sig_we = 1'b0; fre_we = 1'b0;
    map_wa = '0; hnd_wa = '0; sig_wa = '0; fre_wa = freec[AW-1:0];
    map_wd = '0; hnd_wd = '0; sig_wd = '0; fre_wd = '0;
    map_ra = req_id; hnd_ra = dpos[AW-1:0]; sig_ra = dpos[AW-1:0];
    fre_ra = AW'(freec - CW'(1));
    unique case (state)
      S_INIT: begin
        map_we = 1'b1; hnd_we = 1'b1; sig_we = 1'b1;
        map_wa = init_ptr; hnd_wa = init_ptr; sig_wa = init_ptr;
        map_wd = {1'b1, {AW{1'b0}}};
      end
      S_CR_HNDW: begin
        hnd_we = 1'b1; sig_we = 1'b1; hnd_wa = dpos[AW-1:0]; sig_wa = dpos[AW-1:0];
        hnd_wd = oh;
        if (oh[23:0] < 24'(ENTITY_SLOTS)) begin
          map_we = 1'b1; map_wa = oh[AW-1:0]; map_wd = dpos;
        end
      end
      S_SIGW: begin
        // query only reads the signature
        sig_we = (req.req_type == ght_pkg::REQ_ATTACH) ||
                 (req.req_type == ght_pkg::REQ_DETACH);
        sig_wa = dpos[AW-1:0];
        sig_wd = (req.req_type == ght_pkg::REQ_ATTACH) ? (sig_rd | cbit) : (sig_rd & ~cbit);
      end
      S_DS_LAST: begin
        hnd_ra = last[AW-1:0]; sig_ra = last[AW-1:0];
      end
      S_DS_MOVE: begin
        if (dpos != last) begin
          hnd_we = 1'b1; sig_we = 1'b1; hnd_wa = dpos[AW-1:0]; sig_wa = dpos[AW-1:0];
          hnd_wd = mov_h; sig_wd = mov_sig;
          if (mov_h[23:0] < 24'(ENTITY_SLOTS)) begin
            map_we = 1'b1; map_wa = mov_h[AW-1:0]; map_wd = dpos;
          end
        end
      end
      S_DS_FIN: begin
        hnd_we = 1'b1; sig_we = 1'b1; hnd_wa = last[AW-1:0]; sig_wa = last[AW-1:0];
        hnd_wd = {ent_h[31:24] + 8'd1, 24'hFFFFFF};
        if (ent_h[23:0] < 24'(ENTITY_SLOTS)) begin
          map_we = 1'b1; map_wa = ent_h[AW-1:0]; map_wd = {1'b1, {AW{1'b0}}};
        end
        if (freec < SLOTS_C) begin
          fre_we = 1'b1; fre_wd = ent_h[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; init_ptr <= '0; live <= '0; freec <= '0; out_valid <= 1'b0;
      clearing <= 1'b0;
    end else begin
      unique case (state)
        S_INIT: begin
          init_ptr <= init_ptr + AW'(1);
          if (init_ptr == AW'(ENTITY_SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          req <= in_data;
          st <= create_full ? ght_pkg::ST_FULL : ght_pkg::ST_OK;
          oh <= create_full ? '0 : in_data.handle;
          di <= '0; hb <= 1'b0; sm <= '0;
          clearing <= (in_data.req_type == ght_pkg::REQ_CLEAR);
          unique case (in_data.req_type)
            ght_pkg::REQ_CREATE: begin
              if (create_full) state <= S_OUT;
              else begin
                dpos <= live; state <= S_CR_FREE;
              end
            end
            ght_pkg::REQ_DESTROY, ght_pkg::REQ_ATTACH,
            ght_pkg::REQ_DETACH, ght_pkg::REQ_QUERY: state <= S_LOOK;
            ght_pkg::REQ_CLEAR: begin
              if (live == '0) state <= S_OUT;
              else begin
                dpos <= live - CW'(1); last <= live - CW'(1); state <= S_HND;
              end
            end
            default: state <= S_OUT;
          endcase
        end
        S_LOOK: begin
          if (req_is_rmw && comp_bad) begin
            st <= ght_pkg::ST_BADCOMP; state <= S_OUT;
          end else state <= S_MAPW;
        end
        S_MAPW: begin
          // map_rd valid now
          if (!id_in || map_rd >= live) begin
            st <= ght_pkg::ST_INVALID; state <= S_OUT;
          end else begin
            dpos <= map_rd; last <= live - CW'(1); state <= S_HND;
          end
        end
        S_HND: state <= S_HNDW;
        S_HNDW: begin
          ent_h <= hnd_rd;
          if (clearing) state <= S_DS_LAST;
          else if (hnd_rd[31:24] != req.handle[31:24]) begin
            st <= ght_pkg::ST_INVALID; state <= S_OUT;
          end else if (req.req_type == ght_pkg::REQ_DESTROY) state <= S_DS_LAST;
          else state <= S_SIGW;
        end
        S_SIGW: begin
          // sig_rd holds the entity signature
          if (req.req_type == ght_pkg::REQ_ATTACH && (sig_rd & cbit) != '0) begin
            st <= ght_pkg::ST_ALREADY; state <= S_OUT;
          end else begin
            di <= 8'(dpos);
            hb <= (req.req_type == ght_pkg::REQ_QUERY) && ((sig_rd & cbit) != '0);
            unique case (req.req_type)
              ght_pkg::REQ_ATTACH: sm <= ght_pkg::match_mask(cfg, {16'd0, sig_rd | cbit}, SYS_C);
              ght_pkg::REQ_DETACH: sm <= ght_pkg::match_mask(cfg, {16'd0, sig_rd & ~cbit}, SYS_C);
              default:             sm <= ght_pkg::match_mask(cfg, {16'd0, sig_rd}, SYS_C);
            endcase
            state <= S_OUT;
          end
        end
        S_DS_LAST: state <= S_DS_LASTW;
        S_DS_LASTW: begin
          mov_h <= hnd_rd; mov_sig <= sig_rd; state <= S_DS_MOVE;
        end
        S_DS_MOVE: state <= S_DS_FIN;
        S_DS_FIN: begin
          if (freec < SLOTS_C) freec <= freec + CW'(1);
          live <= last;
          if (clearing) begin
            if (last == '0) state <= S_OUT;
            else begin
              dpos <= last - CW'(1); last <= last - CW'(1); state <= S_HND;
            end
          end else begin
            di <= 8'(dpos); state <= S_OUT;
          end
        end
        S_CR_FREE: state <= S_CR_FREEW;
        S_CR_FREEW: begin
          oh[23:0] <= (freec != '0) ? 24'(fre_rd) : 24'(live);
          if (freec != '0) freec <= freec - CW'(1);
          state <= S_CR_HND;
        end
        S_CR_HND: begin
          oh[31:24] <= (hnd_rd[31:24] == 8'd0) ? 8'd1 : hnd_rd[31:24];
          state <= S_CR_HNDW;
        end
        S_CR_HNDW: begin
          live <= live + CW'(1); di <= 8'(dpos); sm <= mask_zero; state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data <= '{status: st, out_handle: oh, dense_index: di, has_bit: hb,
                          system_mask: sm, live_count: 9'(live)};
          end else if (!out_stall) begin
            out_valid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // S_CR_HND uses hnd_rd at dpos (read issued in S_CR_FREEW).
  assign in_stall = (state != S_IDLE);

  // Live count never exceeds the table size.
  a_live_bound: assert property (@(posedge clk) disable iff (rst) live <= SLOTS_C)
    else $error("live count overflow");
  // A create that succeeds grows the live count by one.
  a_create_grow: assert property (@(posedge clk) disable iff (rst)
    state == S_CR_HNDW |=> live == $past(live) + CW'(1))
    else $error("create did not grow table");
  // Results only appear from the output state.
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT)
    else $error("result outside output state");
endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for generational_handle_table.
// Depends on ght_pkg; a built-in slot-map predictor checks every response.
`timescale 1ns / 1ps
module tb;

  localparam int SLOTS = 256;
  localparam int MAX_CYCLES = 3000000;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  ght_pkg::req_t in_data;
  ght_pkg::rsp_t out_data;

  generational_handle_table dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predicted table state
  int          id_pos [SLOTS];   // -1 when the id is not live
  logic [31:0] pos_handle [SLOTS];
  logic [15:0] pos_sig [SLOTS];
  logic [7:0]  free_ids [SLOTS];
  int          free_top, live;
  // Predicted configuration
  logic [4:0]  n_comp;
  logic [2:0]  n_sys;
  logic [15:0] sys_sig [4];

  ght_pkg::rsp_t pending_rsp [$];
  logic [31:0] retired_handles [$];
  int          errors = 0;
  int          cycles = 0;
  int          idle_pct = 0, stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Response checker: every accepted response against the oldest prediction
  always @(posedge clk) begin
    ght_pkg::rsp_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) report("unexpected response", out_data.out_handle, 32'd0);
      else begin
        e = pending_rsp.pop_front();
        if (out_data.status != e.status)
          report("status", 32'(out_data.status), 32'(e.status));
        if (out_data.out_handle != e.out_handle)
          report("handle", out_data.out_handle, e.out_handle);
        if (out_data.dense_index != e.dense_index)
          report("dense", 32'(out_data.dense_index), 32'(e.dense_index));
        if (out_data.has_bit != e.has_bit)
          report("has_bit", 32'(out_data.has_bit), 32'(e.has_bit));
        if (out_data.system_mask != e.system_mask)
          report("mask", 32'(out_data.system_mask), 32'(e.system_mask));
        if (out_data.live_count != e.live_count)
          report("live", 32'(out_data.live_count), 32'(e.live_count));
      end
    end
  end

  function automatic logic [3:0] systems_matched(logic [15:0] sig);
    logic [3:0] m;
    int n;
    m = '0;
    n = (n_sys > 4) ? 4 : n_sys;
    for (int s = 0; s < n; s++)
      if ((sig & sys_sig[s]) == sys_sig[s]) m[s] = 1'b1;
    return m;
  endfunction

  function automatic int find_live(logic [31:0] h);
    int d;
    if (h[23:0] >= SLOTS) return -1;
    d = id_pos[h[23:0]];
    if (d < 0 || d >= live) return -1;
    if (h[31:24] != pos_handle[d][31:24]) return -1;
    return d;
  endfunction

  // Swap-remove: last dense entry fills the hole, slot keeps next generation
  function automatic void retire_at(int d);
    logic [31:0] h, moved;
    int last;
    h = pos_handle[d];
    last = live - 1;
    if (d != last) begin
      moved = pos_handle[last];
      if (moved[23:0] < SLOTS) id_pos[moved[23:0]] = d;
      pos_handle[d] = moved;
      pos_sig[d] = pos_sig[last];
    end
    pos_handle[last] = {h[31:24] + 8'd1, 24'hFFFFFF};
    pos_sig[last] = '0;
    if (h[23:0] < SLOTS) id_pos[h[23:0]] = -1;
    if (free_top < SLOTS) free_ids[free_top++] = h[7:0];
    live = last;
    retired_handles.push_back(h);
    if (retired_handles.size() > 16) void'(retired_handles.pop_front());
  endfunction

  function automatic ght_pkg::rsp_t table_response(ght_pkg::req_t q);
    ght_pkg::rsp_t r;
    int d, id;
    logic [7:0] g;
    logic [15:0] b;
    r = '0;
    r.status = ght_pkg::ST_OK;
    r.out_handle = q.handle;
    case (q.req_type)
      ght_pkg::REQ_CREATE: begin
        if (live >= SLOTS) begin
          r.status = ght_pkg::ST_FULL;
          r.out_handle = '0;
        end else begin
          if (free_top > 0) id = free_ids[--free_top];
          else id = live;
          d = live++;
          g = pos_handle[d][31:24];
          if (g == 0) g = 8'd1;
          r.out_handle = {g, 24'(id)};
          pos_handle[d] = r.out_handle;
          pos_sig[d] = '0;
          id_pos[id] = d;
          r.dense_index = 8'(d);
          r.system_mask = systems_matched('0);
        end
      end
      ght_pkg::REQ_DESTROY: begin
        d = find_live(q.handle);
        if (d < 0) r.status = ght_pkg::ST_INVALID;
        else begin
          retire_at(d);
          r.dense_index = 8'(d);
        end
      end
      ght_pkg::REQ_ATTACH, ght_pkg::REQ_DETACH, ght_pkg::REQ_QUERY: begin
        d = find_live(q.handle);
        if (q.comp_kind >= n_comp || q.comp_kind >= 16) r.status = ght_pkg::ST_BADCOMP;
        else if (d < 0) r.status = ght_pkg::ST_INVALID;
        else begin
          b = 16'd1 << q.comp_kind;
          if (q.req_type == ght_pkg::REQ_ATTACH) begin
            if (pos_sig[d] & b) r.status = ght_pkg::ST_ALREADY;
            else pos_sig[d] |= b;
          end else if (q.req_type == ght_pkg::REQ_DETACH) pos_sig[d] &= ~b;
          else r.has_bit = |(pos_sig[d] & b);
          if (r.status == ght_pkg::ST_OK) begin
            r.dense_index = 8'(d);
            r.system_mask = systems_matched(pos_sig[d]);
          end
        end
      end
      ght_pkg::REQ_CLEAR: while (live > 0) retire_at(live - 1);
      default: ;
    endcase
    r.live_count = 9'(live);
    return r;
  endfunction

  // One request transaction, with an optional random gap in front
  task automatic send(logic [2:0] kind, logic [31:0] h, logic [4:0] cid);
    ght_pkg::req_t q;
    q.req_type = kind;
    q.handle = h;
    q.comp_kind = cid;
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    forever begin
      @(posedge clk);
      if (in_valid && !in_stall) break;
    end
    pending_rsp.push_back(table_response(q));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    forever begin
      @(posedge clk);
      if (cfg_valid && cfg_ready) break;
    end
    case (idx)
      ght_pkg::CFG_NUM_COMP: n_comp = v[4:0];
      ght_pkg::CFG_NUM_SYS:  n_sys = v[2:0];
      default:               sys_sig[idx - ght_pkg::CFG_SIG0] = v;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [4:0] nc, logic [2:0] ns, logic [15:0] s0, logic [15:0] s1,
                            logic [15:0] s2, logic [15:0] s3);
    drain();
    write_reg(ght_pkg::CFG_NUM_COMP, 16'(nc));
    write_reg(ght_pkg::CFG_NUM_SYS, 16'(ns));
    write_reg(ght_pkg::CFG_SIG0, s0);
    write_reg(ght_pkg::CFG_SIG1, s1);
    write_reg(ght_pkg::CFG_SIG2, s2);
    write_reg(ght_pkg::CFG_SIG3, s3);
  endtask

  function automatic logic [31:0] some_handle();
    int r;
    r = $urandom_range(99);
    if (live > 0 && r < 80) return pos_handle[$urandom_range(live - 1)];
    if (retired_handles.size() > 0 && r < 92)
      return retired_handles[$urandom_range(retired_handles.size() - 1)];
    return $urandom;
  endfunction

  function automatic logic [4:0] some_component();
    int lim;
    lim = (n_comp > 16) ? 16 : n_comp;
    if (lim > 0 && $urandom_range(99) < 85) return 5'($urandom_range(lim - 1));
    return 5'($urandom_range(31));
  endfunction

  // Edge cases: bit ops, bad ids, stale handles, swap-remove, reserved codes
  task automatic test_directed();
    logic [31:0] a, b, c;
    send(ght_pkg::REQ_CREATE, 32'hFFFFFFFF, 5'h1F);
    a = pending_rsp[$].out_handle;
    send(ght_pkg::REQ_CREATE, '0, '0);
    b = pending_rsp[$].out_handle;
    send(ght_pkg::REQ_CREATE, '0, '0);
    c = pending_rsp[$].out_handle;
    send(ght_pkg::REQ_ATTACH, a, 5'd0);
    send(ght_pkg::REQ_ATTACH, a, 5'd0);       // already set
    send(ght_pkg::REQ_ATTACH, a, 5'd15);
    send(ght_pkg::REQ_QUERY, a, 5'd15);
    send(ght_pkg::REQ_QUERY, a, 5'd7);
    send(ght_pkg::REQ_QUERY, a, 5'd0);        // query leaves the bit set
    send(ght_pkg::REQ_DETACH, b, 5'd3);       // absent bit
    send(ght_pkg::REQ_ATTACH, b, 5'd16);      // beyond component slots
    send(ght_pkg::REQ_QUERY, 32'hFFFFFFFF, 5'd31);
    send(ght_pkg::REQ_QUERY, 32'h00FFFFFF, 5'd2);
    send(ght_pkg::REQ_DESTROY, a, '0);        // last entry moves into the hole
    send(ght_pkg::REQ_DESTROY, a, '0);        // stale now
    send(ght_pkg::REQ_QUERY, c, 5'd0);
    send(ght_pkg::REQ_RSVD6, c, 5'd1);
    send(ght_pkg::REQ_RSVD7, 32'h5A5A5A5A, 5'd9);
    send(ght_pkg::REQ_DETACH, c, 5'd0);
    send(ght_pkg::REQ_CLEAR, 32'hA5A5A5A5, 5'd4);
    send(ght_pkg::REQ_CREATE, '0, '0);        // generation taken from dense slot
    send(ght_pkg::REQ_QUERY, b, 5'd0);
    drain();
  endtask

  task automatic test_full_table();
    for (int i = 0; i <= SLOTS; i++) send(ght_pkg::REQ_CREATE, '0, '0);
    send(ght_pkg::REQ_DESTROY, pos_handle[17], '0);
    send(ght_pkg::REQ_CREATE, '0, '0);
    send(ght_pkg::REQ_CREATE, '0, '0);
    send(ght_pkg::REQ_CLEAR, '0, '0);
    drain();
  endtask

  // Same slot reused often enough that its generation wraps
  task automatic test_generation_wrap();
    for (int i = 0; i < 260; i++) begin
      send(ght_pkg::REQ_CREATE, '0, '0);
      send(ght_pkg::REQ_DESTROY, pos_handle[0], '0);
    end
    drain();
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(999);
      if (r < 240 + (live < 8 ? 200 : 0))
        send(ght_pkg::REQ_CREATE, $urandom, 5'($urandom));
      else if (r < 420) send(ght_pkg::REQ_DESTROY, some_handle(), 5'($urandom));
      else if (r < 620) send(ght_pkg::REQ_ATTACH, some_handle(), some_component());
      else if (r < 740) send(ght_pkg::REQ_DETACH, some_handle(), some_component());
      else if (r < 960) send(ght_pkg::REQ_QUERY, some_handle(), some_component());
      else if (r < 972) send(ght_pkg::REQ_CLEAR, $urandom, 5'($urandom));
      else send(3'($urandom_range(7)), $urandom, 5'($urandom));
      if (i == n / 2 && $urandom_range(1)) drain();   // let the pipe empty mid-phase
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    out_stall = 1'b0;
    foreach (id_pos[i]) begin
      id_pos[i] = -1;
      pos_handle[i] = '0;
      pos_sig[i] = '0;
    end
    free_top = 0;
    live = 0;
    n_comp = 5'd16;
    n_sys = 3'd0;
    foreach (sys_sig[i]) sys_sig[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    set_config(5'd16, 3'd4, 16'h0000, 16'h0001, 16'h8001, 16'hFFFF);
    test_directed();
    test_full_table();
    test_generation_wrap();

    set_config(5'd16, 3'd4, 16'h0003, 16'h0001, 16'h0102, 16'h0000);
    test_random(80);
    idle_pct = 64;
    set_config(5'd1, 3'd2, 16'h0001, 16'h0000, 16'hFFFF, 16'hFFFF);
    test_random(80);
    idle_pct = 0;
    stall_pct = 64;
    set_config(5'd31, 3'd7, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    test_random(80);
    idle_pct = 12;
    stall_pct = 12;
    set_config(5'd8, 3'd3, 16'h0011, 16'h0022, 16'h0044, 16'h0088);
    test_random(80);
    idle_pct = 30;
    stall_pct = 30;
    set_config(5'd0, 3'd1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    test_random(80);

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
